FILE: rtl/trsu_pkg.sv
// shared types, codes and helper functions of the typed reduction/scan unit
package trsu_pkg;

  localparam int unsigned VAL_W    = 64;
  localparam int unsigned LOC_W    = 32;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned ENTRY_W  = VAL_W + LOC_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REDUCE_OP    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_TYPE = 1'b1;

  localparam logic [CFG_W-1:0] OP_RESET = 4'd2;
  localparam logic [CFG_W-1:0] ET_RESET = 4'd6;

  // element type code boundaries
  localparam logic [CFG_W-1:0] ET_INT_LAST  = 4'd7;
  localparam logic [CFG_W-1:0] ET_PAIR_LAST = 4'd10;
  localparam logic [CFG_W-1:0] ET_PAIR_BASE = 4'd7;

  typedef enum logic [CFG_W-1:0] {
    OP_MIN    = 4'd0,
    OP_MAX    = 4'd1,
    OP_SUM    = 4'd2,
    OP_PROD   = 4'd3,
    OP_LAND   = 4'd4,
    OP_BAND   = 4'd5,
    OP_LOR    = 4'd6,
    OP_BOR    = 4'd7,
    OP_BXOR   = 4'd8,
    OP_MINLOC = 4'd9,
    OP_MAXLOC = 4'd10
  } op_e;

  typedef enum logic [1:0] {
    ACT_INIT_RUN = 2'd0,
    ACT_INIT_RES = 2'd1,
    ACT_APPLY    = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    MODE_HOLD  = 2'd0,
    MODE_INIT  = 2'd1,
    MODE_APPLY = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    W8  = 2'd0,
    W16 = 2'd1,
    W32 = 2'd2,
    W64 = 2'd3
  } wcode_e;

  typedef struct packed {
    wcode_e wcode;
    logic   sg;
    logic   pr;
    logic   err;
  } tinfo_t;

  // accumulator update; a product leaves its partial products for the next stage
  typedef struct packed {
    logic             prod;
    logic [VAL_W-1:0] v;
    logic [LOC_W-1:0] p1;
    logic [LOC_W-1:0] p2;
    logic [LOC_W-1:0] loc;
  } acc_t;

  function automatic logic [VAL_W-1:0] width_mask(wcode_e wc);
    logic [VAL_W-1:0] m;
    m = '1;
    case (wc)
      W8:      m = {{(VAL_W-8){1'b0}}, 8'hff};
      W16:     m = {{(VAL_W-16){1'b0}}, 16'hffff};
      W32:     m = {{(VAL_W-32){1'b0}}, 32'hffff_ffff};
      default: m = '1;
    endcase
    return m;
  endfunction

  function automatic logic [VAL_W-1:0] acc_final(acc_t acc, logic [VAL_W-1:0] m);
    logic [LOC_W-1:0] cross_sum;
    cross_sum = acc.p1 + acc.p2;
    if (acc.prod) begin
      return (acc.v + {cross_sum, {LOC_W{1'b0}}}) & m;
    end
    return acc.v & m;
  endfunction

endpackage

FILE: rtl/trsu_if.sv
// request and result channel interfaces
interface trsu_req_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [9:0]           slot_index;
  logic [63:0]          in_value;
  logic signed [31:0]   in_location;
  logic                 add_to_result;
  logic                 last_element;

  modport source (output valid, action, slot_index, in_value, in_location,
                  add_to_result, last_element, input ready);
  modport sink (input valid, action, slot_index, in_value, in_location,
                add_to_result, last_element, output ready);
endinterface

interface trsu_res_if;
  logic                 valid;
  logic                 ready;
  logic [63:0]          running_value;
  logic signed [31:0]   running_location;
  logic [63:0]          result_value;
  logic signed [31:0]   result_location;
  logic                 op_error;
  logic                 last_out;

  modport source (output valid, running_value, running_location, result_value,
                  result_location, op_error, last_out, input ready);
  modport sink (input valid, running_value, running_location, result_value,
                result_location, op_error, last_out, output ready);
endinterface

FILE: rtl/trsu_alu.sv
// one accumulator update: hold, identity load or typed reduction with an incoming value
module trsu_alu (
  input  trsu_pkg::mode_e             mode_i,
  input  trsu_pkg::op_e               op_i,
  input  trsu_pkg::tinfo_t            tinfo_i,
  input  logic [trsu_pkg::VAL_W-1:0]  a_val_i,
  input  logic [trsu_pkg::LOC_W-1:0]  a_loc_i,
  input  logic [trsu_pkg::VAL_W-1:0]  b_val_i,
  input  logic [trsu_pkg::LOC_W-1:0]  b_loc_i,
  output trsu_pkg::acc_t              acc_o
);
  import trsu_pkg::*;

  logic [VAL_W-1:0] m, am, bm, ka, kb, ident, smax, p0;
  logic [LOC_W-1:0] p1, p2;
  logic             a_lt, a_gt;

  // unsigned compare of keys gives the typed order
  function automatic logic [VAL_W-1:0] order_key(logic [VAL_W-1:0] v, wcode_e wc,
                                                 logic sg);
    logic [VAL_W-1:0] sx;
    case (wc)
      W8:      sx = {{(VAL_W-8){v[7]}}, v[7:0]};
      W16:     sx = {{(VAL_W-16){v[15]}}, v[15:0]};
      W32:     sx = {{(VAL_W-32){v[31]}}, v[31:0]};
      default: sx = v;
    endcase
    if (!sg) begin
      return v;
    end
    return {~sx[VAL_W-1], sx[VAL_W-2:0]};
  endfunction

  assign m    = width_mask(tinfo_i.wcode);
  assign smax = m >> 1;
  assign am   = a_val_i & m;
  assign bm   = b_val_i & m;
  assign ka   = order_key(am, tinfo_i.wcode, tinfo_i.sg);
  assign kb   = order_key(bm, tinfo_i.wcode, tinfo_i.sg);
  assign a_lt = ka < kb;
  assign a_gt = ka > kb;

  // low 64 bits of the product from three 32x32 partial products
  assign p0 = am[LOC_W-1:0] * bm[LOC_W-1:0];
  assign p1 = am[VAL_W-1:LOC_W] * bm[LOC_W-1:0];
  assign p2 = am[LOC_W-1:0] * bm[VAL_W-1:LOC_W];

  always_comb begin
    case (op_i)
      OP_MIN, OP_MINLOC:          ident = tinfo_i.sg ? smax : m;
      OP_MAX, OP_MAXLOC:          ident = tinfo_i.sg ? (smax ^ m) : '0;
      OP_PROD:                    ident = {{(VAL_W-1){1'b0}}, 1'b1};
      OP_LAND, OP_BAND, OP_BXOR:  ident = m;
      default:                    ident = '0;
    endcase
  end

  always_comb begin
    acc_o      = '0;
    acc_o.v    = a_val_i;
    acc_o.loc  = a_loc_i;
    unique case (mode_i)
      MODE_HOLD: begin
      end
      MODE_INIT: begin
        acc_o.v = ident;
        if (tinfo_i.pr) begin
          acc_o.loc = '1;
        end
      end
      MODE_APPLY: begin
        case (op_i)
          OP_MIN:  acc_o.v = a_lt ? am : bm;
          OP_MAX:  acc_o.v = a_gt ? am : bm;
          OP_SUM:  acc_o.v = am + bm;
          OP_PROD: begin
            acc_o.prod = 1'b1;
            acc_o.v    = p0;
            acc_o.p1   = p1;
            acc_o.p2   = p2;
          end
          OP_LAND: acc_o.v = {{(VAL_W-1){1'b0}}, (|am) & (|bm)};
          OP_BAND: acc_o.v = am & bm;
          OP_LOR:  acc_o.v = {{(VAL_W-1){1'b0}}, (|am) | (|bm)};
          OP_BOR:  acc_o.v = am | bm;
          OP_BXOR: acc_o.v = am ^ bm;
          OP_MINLOC: begin
            // incoming pair wins on a tie
            if (!a_lt) begin
              acc_o.v = bm;
              if (tinfo_i.pr) acc_o.loc = b_loc_i;
            end else begin
              acc_o.v = am;
            end
          end
          default: begin
            if (!a_gt) begin
              acc_o.v = bm;
              if (tinfo_i.pr) acc_o.loc = b_loc_i;
            end else begin
              acc_o.v = am;
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/typed_reduction_scan_unit.sv
// top level: per-slot running and result accumulators held in two memories
//
//   channel   dir   handshake             payload
//   req_i     in    valid/ready           action, slot, value, location, flags
//   res_o     out   valid/ready           running/result value+location, error, last
//   cfg       in    cfg_we_i (no wait)    cfg_idx_i, cfg_data_i
//
// one request per cycle sustained while the result side keeps res_o.ready high.
// the request reads its slot from both memories, the alu updates it in the next
// cycle and the write stage writes it back; same-slot requests get the write
// stage value or the last written entry forwarded, so no stall on hazards.
// reset clears the pipeline valids and loads sum / unsigned 64-bit; the memories
// are not cleared. a stalled result holds both stages; ready falls only when
// both stages are full and the result is not taken.
module typed_reduction_scan_unit #(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [trsu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [trsu_pkg::CFG_W-1:0]        cfg_data_i,
  trsu_req_if.sink                          req_i,
  trsu_res_if.source                        res_o
);
  import trsu_pkg::*;

  localparam int unsigned AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned EXT_W = 17;

  // configuration
  logic [CFG_W-1:0] reduce_op_q, element_type_q;
  tinfo_t           tinfo;
  op_e              op;
  logic [VAL_W-1:0] mask;

  // pipeline control
  logic accept, s2_adv, out_take;
  logic s1_valid_q, s1_valid_d, s2_valid_q, s2_valid_d;

  // request stage
  logic [EXT_W-1:0] req_ext;
  logic [AW-1:0]    req_addr;
  logic             req_in_range;

  logic [AW-1:0]    s1_addr_q;
  logic             s1_in_range_q;
  logic [1:0]       s1_action_q;
  logic [VAL_W-1:0] s1_value_q;
  logic [LOC_W-1:0] s1_loc_q;
  logic             s1_add_q, s1_last_q;

  // memories
  logic [ENTRY_W-1:0] run_mem [MAX_ELEMENTS];
  logic [ENTRY_W-1:0] res_mem [MAX_ELEMENTS];
  logic [ENTRY_W-1:0] run_rd_q, res_rd_q;
  logic [ENTRY_W-1:0] run_old, res_old, run_wdata, res_wdata;
  logic               run_we, res_we;

  // alu
  mode_e  run_mode, res_mode;
  acc_t   run_acc, res_acc;
  logic   s1_run_we, s1_res_we;

  // write stage
  logic [AW-1:0]    s2_addr_q;
  logic             s2_in_range_q, s2_err_q, s2_last_q;
  acc_t             s2_run_q, s2_res_q;
  logic             s2_run_we_q, s2_res_we_q;
  logic [VAL_W-1:0] run_fin, res_fin;

  // last entry that left the write stage
  logic [AW-1:0]      wb_addr_q;
  logic               wb_run_v_q, wb_res_v_q;
  logic [ENTRY_W-1:0] wb_run_q, wb_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reduce_op_q    <= OP_RESET;
      element_type_q <= ET_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_REDUCE_OP:    reduce_op_q    <= cfg_data_i;
        REG_ELEMENT_TYPE: element_type_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign op   = op_e'(reduce_op_q);
  assign mask = width_mask(tinfo.wcode);

  always_comb begin
    tinfo       = '0;
    tinfo.wcode = W64;
    if (element_type_q <= ET_INT_LAST) begin
      tinfo.wcode = wcode_e'(element_type_q[2:1]);
      tinfo.sg    = element_type_q[0];
      tinfo.err   = reduce_op_q > OP_BXOR;
    end else if (element_type_q <= ET_PAIR_LAST) begin
      tinfo.wcode = wcode_e'(2'(element_type_q - ET_PAIR_BASE));
      tinfo.sg    = 1'b1;
      tinfo.pr    = 1'b1;
      tinfo.err   = !((op == OP_MINLOC) || (op == OP_MAXLOC));
    end else begin
      tinfo.err   = 1'b1;
    end
  end

  // handshake
  assign out_take    = s2_valid_q && res_o.ready;
  assign s2_adv      = !s2_valid_q || res_o.ready;
  assign req_i.ready = !s1_valid_q || s2_adv;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s2_adv) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_adv ? s1_valid_q : s2_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      wb_run_v_q <= 1'b0;
      wb_res_v_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      if (out_take) begin
        wb_run_v_q <= s2_run_we_q;
        wb_res_v_q <= s2_res_we_q;
      end
    end
  end

  assign req_ext      = EXT_W'(req_i.slot_index);
  assign req_addr     = req_ext[AW-1:0];
  assign req_in_range = req_ext < EXT_W'(MAX_ELEMENTS);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q     <= req_addr;
      s1_in_range_q <= req_in_range;
      s1_action_q   <= req_i.action;
      s1_value_q    <= req_i.in_value;
      s1_loc_q      <= req_i.in_location;
      s1_add_q      <= req_i.add_to_result;
      s1_last_q     <= req_i.last_element;
    end
  end

  // memories: read on accept, write back from the write stage
  assign run_we = s2_valid_q && s2_run_we_q;
  assign res_we = s2_valid_q && s2_res_we_q;

  always_ff @(posedge clk_i) begin
    if (run_we) begin
      run_mem[s2_addr_q] <= run_wdata;
    end
    if (accept) begin
      run_rd_q <= run_mem[req_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_mem[s2_addr_q] <= res_wdata;
    end
    if (accept) begin
      res_rd_q <= res_mem[req_addr];
    end
  end

  // forwarding of writes the registered read did not see
  always_comb begin
    run_old = run_rd_q;
    if (run_we && (s2_addr_q == s1_addr_q)) begin
      run_old = run_wdata;
    end else if (wb_run_v_q && (wb_addr_q == s1_addr_q)) begin
      run_old = wb_run_q;
    end
    res_old = res_rd_q;
    if (res_we && (s2_addr_q == s1_addr_q)) begin
      res_old = res_wdata;
    end else if (wb_res_v_q && (wb_addr_q == s1_addr_q)) begin
      res_old = wb_res_q;
    end
  end

  always_comb begin
    run_mode = MODE_HOLD;
    res_mode = MODE_HOLD;
    if (s1_in_range_q && !tinfo.err) begin
      case (s1_action_q)
        ACT_INIT_RUN: run_mode = MODE_INIT;
        ACT_INIT_RES: res_mode = MODE_INIT;
        ACT_APPLY: begin
          run_mode = MODE_APPLY;
          if (s1_add_q) res_mode = MODE_APPLY;
        end
        default: begin
        end
      endcase
    end
  end

  assign s1_run_we = run_mode != MODE_HOLD;
  assign s1_res_we = res_mode != MODE_HOLD;

  trsu_alu u_run_alu (
    .mode_i  (run_mode),
    .op_i    (op),
    .tinfo_i (tinfo),
    .a_val_i (run_old[VAL_W-1:0]),
    .a_loc_i (run_old[ENTRY_W-1:VAL_W]),
    .b_val_i (s1_value_q),
    .b_loc_i (s1_loc_q),
    .acc_o   (run_acc)
  );

  trsu_alu u_res_alu (
    .mode_i  (res_mode),
    .op_i    (op),
    .tinfo_i (tinfo),
    .a_val_i (res_old[VAL_W-1:0]),
    .a_loc_i (res_old[ENTRY_W-1:VAL_W]),
    .b_val_i (s1_value_q),
    .b_loc_i (s1_loc_q),
    .acc_o   (res_acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_run_we_q <= 1'b0;
      s2_res_we_q <= 1'b0;
    end else if (s2_adv) begin
      s2_run_we_q <= s1_valid_q && s1_run_we;
      s2_res_we_q <= s1_valid_q && s1_res_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      s2_addr_q     <= s1_addr_q;
      s2_in_range_q <= s1_in_range_q;
      s2_err_q      <= tinfo.err;
      s2_last_q     <= s1_last_q;
      s2_run_q      <= run_acc;
      s2_res_q      <= res_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      wb_addr_q <= s2_addr_q;
      wb_run_q  <= run_wdata;
      wb_res_q  <= res_wdata;
    end
  end

  // product partials are summed here
  assign run_fin   = acc_final(s2_run_q, mask);
  assign res_fin   = acc_final(s2_res_q, mask);
  assign run_wdata = {s2_run_q.loc, run_fin};
  assign res_wdata = {s2_res_q.loc, res_fin};

  assign res_o.valid            = s2_valid_q;
  assign res_o.running_value    = s2_in_range_q ? run_fin : '0;
  assign res_o.result_value     = s2_in_range_q ? res_fin : '0;
  assign res_o.running_location = (s2_in_range_q && tinfo.pr) ? s2_run_q.loc : '0;
  assign res_o.result_location  = (s2_in_range_q && tinfo.pr) ? s2_res_q.loc : '0;
  assign res_o.op_error         = s2_err_q;
  assign res_o.last_out         = s2_last_q;

`ifndef SYNTHESIS
  a_we_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_we || res_we) |-> (s2_in_range_q && !s2_err_q))
    else $error("memory write from an out-of-range or mismatched request");

  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (s1_valid_q && s2_valid_q && !res_o.ready))
    else $error("ready low without a full pipeline");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_valid_q && !res_o.ready) |=> s1_valid_q)
    else $error("request lost from the alu stage during a stall");

  a_s2_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_adv) |=> s2_valid_q)
    else $error("request lost between alu and write stage");
`endif

endmodule

FILE: tb/typed_reduction_scan_unit_tb.sv
// self-checking testbench of the typed reduction/scan unit
module typed_reduction_scan_unit_tb;
  import trsu_pkg::*;

  localparam int unsigned SLOTS       = 1024;
  localparam int unsigned PIPE_LAT    = 4;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned ITEM_TARGET = 1950;

  // element type codes
  localparam logic [CFG_W-1:0] ET_U8  = 4'd0;
  localparam logic [CFG_W-1:0] ET_P16 = 4'd8;
  localparam logic [CFG_W-1:0] ET_P64 = 4'd10;
  localparam logic [CFG_W-1:0] ET_UNUSED_LO = 4'd11;
  localparam logic [CFG_W-1:0] CODE_TOP = 4'd15;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  action;
    logic [9:0]  slot;
    logic [63:0] value;
    logic [31:0] location;
    logic        add;
    logic        last_el;
  } req_item_t;

  typedef struct {
    logic [63:0] run_val;
    logic [31:0] run_loc;
    logic [63:0] res_val;
    logic [31:0] res_loc;
    logic        err;
    logic        last_el;
    bit          chk_rv;
    bit          chk_rl;
    bit          chk_sv;
    bit          chk_sl;
  } readback_t;

  class accumulator_tracker;
    logic [CFG_W-1:0] op_reg;
    logic [CFG_W-1:0] type_reg;
    bit [63:0] run_val [SLOTS];
    bit [31:0] run_loc [SLOTS];
    bit [63:0] res_val [SLOTS];
    bit [31:0] res_loc [SLOTS];
    // which entries hold a written value
    bit kn_rv [SLOTS];
    bit kn_rl [SLOTS];
    bit kn_sv [SLOTS];
    bit kn_sl [SLOTS];
    readback_t readback_q [$];
    int errors;

    function new();
      op_reg = OP_RESET;
      type_reg = ET_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_REDUCE_OP) op_reg = val;
      else type_reg = val;
    endfunction

    function void decode(output int unsigned w, output bit sg, output bit pr,
                         output bit ok);
      if (type_reg <= ET_INT_LAST) begin
        w = 8 << type_reg[3:1];
        sg = type_reg[0];
        pr = 1'b0;
        ok = 1'b1;
      end else if (type_reg <= ET_PAIR_LAST) begin
        w = 16 << (type_reg - ET_P16);
        sg = 1'b1;
        pr = 1'b1;
        ok = 1'b1;
      end else begin
        // undefined codes behave as plain 64-bit
        w = 64;
        sg = 1'b0;
        pr = 1'b0;
        ok = 1'b0;
      end
    endfunction

    function bit pair_type();
      return type_reg > ET_INT_LAST && type_reg <= ET_PAIR_LAST;
    endfunction

    function bit side_ready(int s, bit result_side);
      if (result_side) return kn_sv[s] && (!pair_type() || kn_sl[s]);
      return kn_rv[s] && (!pair_type() || kn_rl[s]);
    endfunction

    function bit slot_ready(int s);
      return side_ready(s, 1'b0) && side_ready(s, 1'b1);
    endfunction

    function bit [63:0] lane_mask(int unsigned w);
      if (w >= 64) return '1;
      return (64'd1 << w) - 64'd1;
    endfunction

    // flips signed values so that an unsigned compare orders them
    function bit [63:0] sort_key(bit [63:0] v, int unsigned w, bit sg);
      bit [63:0] m;
      m = lane_mask(w);
      v &= m;
      if (!sg) return v;
      if (v[w-1]) v |= ~m;
      return v ^ {1'b1, 63'd0};
    endfunction

    function bit [63:0] identity_of(logic [CFG_W-1:0] op, int unsigned w, bit sg);
      bit [63:0] m;
      bit [63:0] smax;
      m = lane_mask(w);
      smax = m >> 1;
      case (op) inside
        OP_MIN, OP_MINLOC: return sg ? smax : m;
        OP_MAX, OP_MAXLOC: return sg ? (smax ^ m) : 64'd0;
        OP_PROD: return 64'd1;
        OP_LAND, OP_BAND, OP_BXOR: return m;
        default: return 64'd0;
      endcase
    endfunction

    function bit [63:0] fold(logic [CFG_W-1:0] op, bit [63:0] a, bit [63:0] b,
                             int unsigned w, bit sg, output bit take_in);
      bit [63:0] m;
      bit [63:0] ka;
      bit [63:0] kb;
      m = lane_mask(w);
      ka = sort_key(a, w, sg);
      kb = sort_key(b, w, sg);
      a &= m;
      b &= m;
      take_in = 1'b0;
      case (op)
        OP_MIN:  return (ka < kb) ? a : b;
        OP_MAX:  return (ka > kb) ? a : b;
        OP_SUM:  return (a + b) & m;
        OP_PROD: return (a * b) & m;
        OP_LAND: return (a != 0 && b != 0) ? 64'd1 : 64'd0;
        OP_BAND: return a & b;
        OP_LOR:  return (a != 0 || b != 0) ? 64'd1 : 64'd0;
        OP_BOR:  return a | b;
        OP_BXOR: return a ^ b;
        OP_MINLOC: begin
          // incoming pair wins a tie
          take_in = !(ka < kb);
          return take_in ? b : a;
        end
        default: begin
          take_in = !(ka > kb);
          return take_in ? b : a;
        end
      endcase
    endfunction

    function void note_request(req_item_t it);
      int unsigned w;
      bit sg;
      bit pr;
      bit ok;
      bit err;
      bit take;
      bit [63:0] m;
      bit [63:0] id;
      int s;
      readback_t want;
      decode(w, sg, pr, ok);
      if (!ok) err = 1'b1;
      else if (pr) err = !(op_reg == OP_MINLOC || op_reg == OP_MAXLOC);
      else err = op_reg > OP_BXOR;
      m = lane_mask(w);
      s = it.slot;
      if (!err) begin
        id = identity_of(op_reg, w, sg);
        case (it.action)
          ACT_INIT_RUN: begin
            run_val[s] = id;
            kn_rv[s] = 1'b1;
            if (pr) begin
              run_loc[s] = '1;
              kn_rl[s] = 1'b1;
            end
          end
          ACT_INIT_RES: begin
            res_val[s] = id;
            kn_sv[s] = 1'b1;
            if (pr) begin
              res_loc[s] = '1;
              kn_sl[s] = 1'b1;
            end
          end
          ACT_APPLY: begin
            run_val[s] = fold(op_reg, run_val[s], it.value, w, sg, take);
            if (pr && take) begin
              run_loc[s] = it.location;
              kn_rl[s] = 1'b1;
            end
            if (it.add) begin
              res_val[s] = fold(op_reg, res_val[s], it.value, w, sg, take);
              if (pr && take) begin
                res_loc[s] = it.location;
                kn_sl[s] = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      want.run_val = run_val[s] & m;
      want.run_loc = pr ? run_loc[s] : '0;
      want.res_val = res_val[s] & m;
      want.res_loc = pr ? res_loc[s] : '0;
      want.err = err;
      want.last_el = it.last_el;
      // the other side of a slot's very first init is not written yet
      want.chk_rv = kn_rv[s];
      want.chk_rl = !pr || kn_rl[s];
      want.chk_sv = kn_sv[s];
      want.chk_sl = !pr || kn_sl[s];
      readback_q.push_back(want);
    endfunction

    function void check_readback(readback_t got);
      readback_t want;
      if (readback_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      want = readback_q.pop_front();
      if (want.chk_rv && got.run_val !== want.run_val) begin
        $error("running_value expected %h actual %h", want.run_val, got.run_val);
        errors++;
      end
      if (want.chk_rl && got.run_loc !== want.run_loc) begin
        $error("running_location expected %h actual %h", want.run_loc, got.run_loc);
        errors++;
      end
      if (want.chk_sv && got.res_val !== want.res_val) begin
        $error("result_value expected %h actual %h", want.res_val, got.res_val);
        errors++;
      end
      if (want.chk_sl && got.res_loc !== want.res_loc) begin
        $error("result_location expected %h actual %h", want.res_loc, got.res_loc);
        errors++;
      end
      if (got.err !== want.err) begin
        $error("op_error expected %b actual %b", want.err, got.err);
        errors++;
      end
      if (got.last_el !== want.last_el) begin
        $error("last_out expected %b actual %b", want.last_el, got.last_el);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  trsu_req_if req_ch ();
  trsu_res_if res_ch ();

  typed_reduction_scan_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_ch),
    .res_o      (res_ch)
  );

  accumulator_tracker sb;
  bit req_take;
  bit res_take;
  readback_t res_seen;
  int send_idle_pct;
  int res_stall_pct;

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // handshakes are sampled mid-cycle, where nothing moves
  always @(negedge clk_i) begin
    req_take = (rst_ni === 1'b1) && (req_ch.valid === 1'b1) && (req_ch.ready === 1'b1);
    res_take = (rst_ni === 1'b1) && (res_ch.valid === 1'b1) && (res_ch.ready === 1'b1);
    res_seen.run_val = res_ch.running_value;
    res_seen.run_loc = res_ch.running_location;
    res_seen.res_val = res_ch.result_value;
    res_seen.res_loc = res_ch.result_location;
    res_seen.err = res_ch.op_error;
    res_seen.last_el = res_ch.last_out;
  end

  always @(posedge clk_i) begin
    if (res_take) sb.check_readback(res_seen);
    res_ch.ready <= ($urandom_range(99, 0) >= res_stall_pct);
  end

  function automatic req_item_t mk_item(logic [1:0] act, logic [9:0] slot,
                                        logic [63:0] v, logic [31:0] loc,
                                        logic add, logic last_el);
    req_item_t it;
    it.action = act;
    it.slot = slot;
    it.value = v;
    it.location = loc;
    it.add = add;
    it.last_el = last_el;
    return it;
  endfunction

  function automatic logic [63:0] rand_value();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return '1;
      2: return 64'($urandom_range(3, 0));
      3: return -64'($urandom_range(2, 1));
      4: return 64'd1 << $urandom_range(63, 0);
      5: return ~(64'd1 << $urandom_range(63, 0));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] rand_location();
    case ($urandom_range(3, 0))
      0: return 32'($urandom_range(3, 0)) - 32'd1;
      1: return {1'b1, 31'd0};
      default: return $urandom;
    endcase
  endfunction

  // mostly a small window of slots so that accumulations build up
  function automatic bit pick_item(logic [9:0] base, bit cfg_bad, output req_item_t it);
    logic [9:0] s;
    int tries;
    int r;
    it = mk_item(ACT_APPLY, '0, rand_value(), rand_location(), 1'($urandom),
                 ($urandom_range(7, 0) == 0));
    s = base;
    for (tries = 0; tries < 8; tries++) begin
      s = ($urandom_range(19, 0) == 0) ? 10'($urandom) : base + 10'($urandom_range(7, 0));
      if (sb.slot_ready(s)) break;
    end
    it.slot = s;
    if (!sb.slot_ready(s)) begin
      if (cfg_bad) return 1'b0;
      it.action = sb.side_ready(s, 1'b0) ? ACT_INIT_RES : ACT_INIT_RUN;
      return 1'b1;
    end
    r = $urandom_range(99, 0);
    if (r < 78) it.action = ACT_APPLY;
    else if (r < 88) it.action = ACT_INIT_RUN;
    else if (r < 97) it.action = ACT_INIT_RES;
    else it.action = ACT_UNUSED;
    return 1'b1;
  endfunction

  task automatic send_request(req_item_t it);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= it.action;
    req_ch.slot_index <= it.slot;
    req_ch.in_value <= it.value;
    req_ch.in_location <= it.location;
    req_ch.add_to_result <= it.add;
    req_ch.last_element <= it.last_el;
    @(posedge clk_i);
    while (!req_take) @(posedge clk_i);
    sb.note_request(it);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.readback_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT) @(posedge clk_i);
  endtask

  task automatic configure(logic [CFG_W-1:0] op, logic [CFG_W-1:0] et);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_REDUCE_OP;
    cfg_data_i <= op;
    @(posedge clk_i);
    cfg_idx_i <= REG_ELEMENT_TYPE;
    cfg_data_i <= et;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(REG_REDUCE_OP, op);
    sb.set_reg(REG_ELEMENT_TYPE, et);
  endtask

  task automatic run_directed();
    int k;
    logic [CFG_W-1:0] et;
    logic [63:0] edge_val;
    // reset setting: sum over unsigned 64-bit, wrapping
    send_request(mk_item(ACT_INIT_RUN, '0, '0, '0, 1'b0, 1'b0));
    send_request(mk_item(ACT_INIT_RES, '0, '0, '0, 1'b0, 1'b0));
    send_request(mk_item(ACT_APPLY, '0, '1, '0, 1'b1, 1'b0));
    for (k = int'(OP_MIN); k <= int'(OP_MAXLOC); k++) begin
      if (k == int'(OP_MINLOC)) et = ET_P16;
      else if (k == int'(OP_MAXLOC)) et = ET_P64;
      else et = 4'(k % 8);
      edge_val = k[0] ? '1 : {1'b1, 63'd0};
      configure(4'(k), et);
      send_request(mk_item(ACT_INIT_RUN, '0, '0, '0, 1'b0, 1'b0));
      if (k == int'(OP_MINLOC)) send_request(mk_item(ACT_INIT_RES, '0, '0, '0, 1'b0, 1'b0));
      send_request(mk_item(ACT_APPLY, '0, edge_val, {1'b1, 31'd0}, 1'b1, 1'b1));
    end
    // undefined operation on a pair type
    configure(CODE_TOP, ET_P64);
    send_request(mk_item(ACT_APPLY, '0, '1, '1, 1'b1, 1'b0));
    // undefined element type, read at 64 bits
    configure(OP_MIN, CODE_TOP);
    send_request(mk_item(ACT_APPLY, '0, '0, '0, 1'b1, 1'b1));
    // pair operation on an integer type, with the unused action
    configure(OP_MAXLOC, ET_U8);
    send_request(mk_item(ACT_UNUSED, '0, '1, '0, 1'b1, 1'b0));
  endtask

  task automatic run_random();
    int sent;
    int phase;
    int len;
    int n;
    logic [9:0] base;
    bit bad;
    bit prev_bad;
    bit prev_pair;
    logic [CFG_W-1:0] op;
    logic [CFG_W-1:0] et;
    req_item_t it;
    sent = 0;
    phase = 0;
    prev_bad = 1'b1;
    prev_pair = 1'b0;
    base = '0;
    while (sent < ITEM_TARGET) begin
      bad = !prev_bad && ($urandom_range(99, 0) < 15);
      if (bad) begin
        // same window and pair kind as the phase before, so the slots are written
        if (prev_pair) begin
          et = 4'($urandom_range(ET_P64, ET_P16));
          do op = 4'($urandom_range(CODE_TOP, OP_MIN));
          while (op == OP_MINLOC || op == OP_MAXLOC);
        end else if ($urandom_range(1, 0) == 0) begin
          et = 4'($urandom_range(ET_INT_LAST, ET_U8));
          op = 4'($urandom_range(CODE_TOP, OP_MINLOC));
        end else begin
          et = 4'($urandom_range(CODE_TOP, ET_UNUSED_LO));
          op = 4'($urandom_range(CODE_TOP, OP_MIN));
        end
      end else begin
        base = 10'($urandom);
        if ($urandom_range(99, 0) < 25) begin
          et = 4'($urandom_range(ET_P64, ET_P16));
          op = 4'($urandom_range(OP_MAXLOC, OP_MINLOC));
        end else begin
          et = 4'($urandom_range(ET_INT_LAST, ET_U8));
          op = 4'($urandom_range(OP_BXOR, OP_MIN));
        end
      end
      case (phase % 4)
        0: begin send_idle_pct = 0;  res_stall_pct = 0;  end
        1: begin send_idle_pct = 51; res_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  res_stall_pct = 51; end
        default: begin send_idle_pct = 38; res_stall_pct = 38; end
      endcase
      configure(op, et);
      len = bad ? $urandom_range(20, 8) : $urandom_range(70, 25);
      for (n = 0; n < len; n++) begin
        if (pick_item(base, bad, it)) begin
          send_request(it);
          sent++;
        end
      end
      if (!bad) prev_pair = sb.pair_type();
      prev_bad = bad;
      phase++;
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0;
    res_stall_pct = 0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    req_ch.valid <= 1'b0;
    req_ch.action <= '0;
    req_ch.slot_index <= '0;
    req_ch.in_value <= '0;
    req_ch.in_location <= '0;
    req_ch.add_to_result <= 1'b0;
    req_ch.last_element <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    drain();
    if (sb.errors == 0 && sb.readback_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // ends a run in which requests or results stop moving
  initial begin
    int stuck;
    stuck = 0;
    @(posedge rst_ni);
    while (stuck < STALL_LIMIT) begin
      @(posedge clk_i);
      if (req_take || res_take) stuck = 0;
      else stuck++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/trsu_pkg.sv
rtl/trsu_if.sv
rtl/trsu_alu.sv
rtl/typed_reduction_scan_unit.sv
tb/typed_reduction_scan_unit_tb.sv
